>>> src/nscs_pkg.sv
// ----------------------------------------------------------------------------
// nscs_pkg
// shared types and constants of the start code splitter
// ----------------------------------------------------------------------------
package nscs_pkg;

  localparam int unsigned OutLenWidth = 24;
  localparam int unsigned CntWidth    = 3;

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // one classified item: held zeros to release, the byte itself, and up to
  // two end markers (start code, then stream end)
  typedef struct packed {
    logic [7:0]             data;
    logic [1:0]             zeros;
    logic                   has_byte;
    logic                   sc_end;
    logic [OutLenWidth-1:0] sc_len;
    logic                   se_end;
    logic [OutLenWidth-1:0] se_len;
  } cmd_t;

endpackage

>>> src/nal_start_code_splitter.sv
// path: a taken item is queued as a command, then its results go out through the output register
// throughput: one item per cycle while each gives at most one result and the output is not stalled;
//   an item giving k results holds the back end until its last result is taken (one result per cycle)
// reset: asynchronous, active low; clears parser state, queue and output
//   valid flag, parser starts searching for the first start code
// ----------------------------------------------------------------------------
// nal_start_code_splitter
// splits an annex b byte stream into nal units at 3- and 4-byte start codes
// ----------------------------------------------------------------------------
module nal_start_code_splitter import nscs_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel, one stream byte per item
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   stream_start_i,
  input  logic                   stream_end_i,
  // output channel, one payload byte or end marker per item
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   unit_end_o,
  output logic [OutLenWidth-1:0] unit_length_o,
  output logic                   last_of_input_o
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic fifo_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  // the front takes an item whenever the queue has room; the parser state
  // updates in the same cycle so the next byte may follow straight away
  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && !fifo_full;

  // classification: held zeros, the byte, start code and stream end markers;
  // the unit length is tracked here, saturating at LENGTH_WIDTH bits
  nscs_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .stream_start_i (stream_start_i),
    .stream_end_i   (stream_end_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  // items that give no result are never queued
  nscs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_valid),
    .push_data_i  (cmd),
    .pop_i        (pop),
    .full_o       (fifo_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back end walks the head command one result per cycle, while the output
  // is not stalled, into the output register, popping it with the last result
  nscs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .unit_end_o      (unit_end_o),
    .unit_length_o   (unit_length_o),
    .last_of_input_o (last_of_input_o)
  );

endmodule

>>> src/nscs_front.sv
// ----------------------------------------------------------------------------
// nscs_front
// parser state and classification of each accepted item into a command
// ----------------------------------------------------------------------------
module nscs_front import nscs_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  input  logic       stream_end_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  localparam logic [LENGTH_WIDTH-1:0] LenMax = {LENGTH_WIDTH{1'b1}};

  logic                    in_payload_q, in_payload_d;
  logic [1:0]              zero_cnt_q, zero_cnt_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;

  logic                    ip;
  logic [1:0]              zc;
  logic [LENGTH_WIDTH-1:0] len_base;
  logic [LENGTH_WIDTH:0]   len_sum;
  logic [LENGTH_WIDTH-1:0] len_new;
  logic [2:0]              n_bytes;
  logic [31:0]             old_len32;
  logic [31:0]             new_len32;
  cmd_t                    cmd;

  always_comb begin
    ip       = stream_start_i ? 1'b0 : in_payload_q;
    zc       = stream_start_i ? 2'd0 : zero_cnt_q;
    len_base = stream_start_i ? '0 : len_q;
    old_len32 = 32'(len_base);

    cmd          = '0;
    cmd.data     = in_byte_i;
    in_payload_d = ip;
    zero_cnt_d   = zc;

    priority if (in_byte_i == ByteZero) begin
      if (zc != 2'd3) begin
        zero_cnt_d = zc + 2'd1;
      end else if (ip) begin
        cmd.zeros = 2'd1;
      end
    end else if (in_byte_i == ByteOne && zc >= 2'd2) begin
      // start code: close the unit if one is open, length restarts
      cmd.sc_end   = ip;
      cmd.sc_len   = old_len32[OutLenWidth-1:0];
      in_payload_d = 1'b1;
      len_base     = '0;
      zero_cnt_d   = 2'd0;
    end else begin
      if (ip) begin
        cmd.zeros    = zc;
        cmd.has_byte = 1'b1;
      end
      zero_cnt_d = 2'd0;
    end

    n_bytes   = {1'b0, cmd.zeros} + {2'b00, cmd.has_byte};
    len_sum   = {1'b0, len_base} + (LENGTH_WIDTH+1)'(n_bytes);
    len_new   = len_sum[LENGTH_WIDTH] ? LenMax : len_sum[LENGTH_WIDTH-1:0];
    new_len32 = 32'(len_new);
    len_d     = len_new;

    if (stream_end_i) begin
      cmd.se_end   = 1'b1;
      cmd.se_len   = new_len32[OutLenWidth-1:0];
      in_payload_d = 1'b0;
      zero_cnt_d   = 2'd0;
      len_d        = '0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i &&
                       (cmd.zeros != 2'd0 || cmd.has_byte || cmd.sc_end || cmd.se_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      zero_cnt_q   <= 2'd0;
      len_q        <= '0;
    end else if (accept_i) begin
      in_payload_q <= in_payload_d;
      zero_cnt_q   <= zero_cnt_d;
      len_q        <= len_d;
    end
  end

endmodule

>>> src/nscs_fifo.sv
// ----------------------------------------------------------------------------
// nscs_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module nscs_fifo import nscs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = count_q == 2'd2;
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> src/nscs_back.sv
// ----------------------------------------------------------------------------
// nscs_back
// expands a queued command into its results through an output register
// ----------------------------------------------------------------------------
module nscs_back import nscs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  cmd_t                   head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   unit_end_o,
  output logic [OutLenWidth-1:0] unit_length_o,
  output logic                   last_of_input_o
);

  logic [CntWidth-1:0]    idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             byte_q, byte_d;
  logic                   bvalid_q, bvalid_d;
  logic                   uend_q, uend_d;
  logic [OutLenWidth-1:0] ulen_q, ulen_d;
  logic                   last_q, last_d;

  logic                   load;
  logic [CntWidth-1:0]    n_res;
  logic [CntWidth-1:0]    n_pre;
  logic                   is_last;

  always_comb begin
    load    = head_valid_i && (!out_valid_q || out_ready_i);
    n_pre   = CntWidth'(head_i.zeros) + CntWidth'(head_i.has_byte);
    n_res   = n_pre + CntWidth'(head_i.sc_end) + CntWidth'(head_i.se_end);
    is_last = idx_q == n_res - CntWidth'(1);

    byte_d   = ByteZero;
    bvalid_d = 1'b0;
    uend_d   = 1'b0;
    ulen_d   = '0;
    priority if (idx_q < CntWidth'(head_i.zeros)) begin
      bvalid_d = 1'b1;
    end else if (idx_q < n_pre) begin
      byte_d   = head_i.data;
      bvalid_d = 1'b1;
    end else if (head_i.sc_end && idx_q == n_pre) begin
      uend_d = 1'b1;
      ulen_d = head_i.sc_len;
    end else begin
      uend_d = 1'b1;
      ulen_d = head_i.se_len;
    end
    last_d = is_last;

    out_valid_d = load || (out_valid_q && !out_ready_i);
    idx_d       = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + CntWidth'(1);
    end
  end

  assign pop_o           = load && is_last;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bvalid_q;
  assign unit_end_o      = uend_q;
  assign unit_length_o   = ulen_q;
  assign last_of_input_o = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      uend_q   <= uend_d;
      ulen_q   <= ulen_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> test/nal_start_code_splitter_tb.sv
// ----------------------------------------------------------------------------
// nal_start_code_splitter_tb
// self-checking bench for the annex b start code splitter: a queue-fed driver
// sends stream bytes with random gaps, a predictor works out the payload bytes
// and end markers each accepted byte should give, and a monitor with random
// back-pressure checks every result against them in order
// ----------------------------------------------------------------------------
module nal_start_code_splitter_tb import nscs_pkg::*;;

  localparam int unsigned LenMax   = (1 << OutLenWidth) - 1;
  localparam int unsigned MaxGap   = 13;
  localparam int unsigned RandBytes = 270;
  localparam int unsigned MaxPrint = 20;

  // one stream byte as queued for the driver
  typedef struct {
    logic [7:0]  data;
    logic        ss;
    logic        se;
    int unsigned gap;
    bit          drain;   // not a byte: hold the sender until all results are in
  } feed_t;

  // one result item as the block should show it
  typedef struct {
    logic [7:0]             data;
    logic                   is_byte;
    logic                   is_end;
    logic [OutLenWidth-1:0] len;
    logic                   last;
  } result_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             in_byte_i      = 8'h00;
  logic                   stream_start_i = 1'b0;
  logic                   stream_end_i   = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b0;
  logic [7:0]             out_byte_o;
  logic                   byte_valid_o;
  logic                   unit_end_o;
  logic [OutLenWidth-1:0] unit_length_o;
  logic                   last_of_input_o;

  nal_start_code_splitter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .stream_start_i (stream_start_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .unit_end_o     (unit_end_o),
    .unit_length_o  (unit_length_o),
    .last_of_input_o(last_of_input_o)
  );

  // stimulus and expectation stores
  feed_t       byte_feed[$];
  result_t     expected_out[$];

  // predictor state: parser position, held zeros, length of the open unit
  logic                   pr_in_unit;
  logic [1:0]             pr_zeros;
  logic [OutLenWidth-1:0] pr_len;

  int unsigned n_errors    = 0;
  int unsigned n_printed   = 0;
  int unsigned n_bytes_in  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_markers   = 0;
  int unsigned n_drains    = 0;
  bit          calm        = 1'b0;   // stretch with no idling on either side
  bit          feed_done   = 1'b0;

  // clock and the one reset pulse
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void pass_byte(ref result_t batch[$], input logic [7:0] b);
    batch.push_back('{b, 1'b1, 1'b0, '0, 1'b0});
    if (pr_len != OutLenWidth'(LenMax)) pr_len++;
  endfunction

  // work out every result one accepted stream byte gives, in order
  function automatic void split_predict(input feed_t f);
    result_t batch[$];
    int k;
    if (f.ss) begin
      pr_in_unit = 1'b0;
      pr_zeros   = '0;
      pr_len     = '0;
    end
    if (f.data == ByteZero) begin
      // a run of zeros longer than three: count stays, one zero goes out inside a unit
      if (pr_zeros < 2'd3) pr_zeros++;
      else if (pr_in_unit) pass_byte(batch, ByteZero);
    end else if (f.data == ByteOne && pr_zeros >= 2'd2) begin
      // start code: closes an open unit, or opens the first one
      if (pr_in_unit) batch.push_back('{8'h00, 1'b0, 1'b1, pr_len, 1'b0});
      pr_in_unit = 1'b1;
      pr_len     = '0;
      pr_zeros   = '0;
    end else begin
      // held zeros were payload after all
      if (pr_in_unit) begin
        for (k = 0; k < int'(pr_zeros); k++) pass_byte(batch, ByteZero);
        pass_byte(batch, f.data);
      end
      pr_zeros = '0;
    end
    if (f.se) begin
      // stream end always closes, held zeros dropped
      batch.push_back('{8'h00, 1'b0, 1'b1, pr_len, 1'b0});
      pr_in_unit = 1'b0;
      pr_zeros   = '0;
      pr_len     = '0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_out.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued bytes, each after its own gap
  // ---------------------------------------------------------------------------
  feed_t       cur_item;
  feed_t       staged;
  bit          staged_ok = 1'b0;
  int unsigned gap_left  = 0;

  always @(posedge clk_i) begin
    logic hold;
    hold = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        split_predict(cur_item);
        n_bytes_in++;
        hold = 1'b0;
      end
      if (!hold) begin
        if (!staged_ok && byte_feed.size() > 0) begin
          staged    = byte_feed.pop_front();
          staged_ok = 1'b1;
          gap_left  = staged.gap;
        end
        if (staged_ok && staged.drain) begin
          // sender pauses until the block has given everything owed
          if (expected_out.size() == 0) begin
            staged_ok = 1'b0;
            n_drains++;
          end
        end else if (staged_ok) begin
          if (gap_left == 0) begin
            cur_item  = staged;
            staged_ok = 1'b0;
            hold      = 1'b1;
          end else begin
            gap_left--;
          end
        end
      end
    end
    in_valid_i     <= hold;
    in_byte_i      <= cur_item.data;
    stream_start_i <= cur_item.ss;
    stream_end_i   <= cur_item.se;
  end

  // ---------------------------------------------------------------------------
  // monitor: random stalls on the result side, in-order check
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_out.size() == 0) begin
          n_errors++;
          if (n_printed < MaxPrint) begin
            n_printed++;
            $display("%0t: result with nothing expected: byte %02h bv %b end %b len %0d last %b",
                     $time, out_byte_o, byte_valid_o, unit_end_o, unit_length_o,
                     last_of_input_o);
          end
        end else begin
          want = expected_out.pop_front();
          n_checked++;
          if (want.is_end) n_markers++;
          if (out_byte_o !== want.data || byte_valid_o !== want.is_byte ||
              unit_end_o !== want.is_end || unit_length_o !== want.len ||
              last_of_input_o !== want.last) begin
            n_errors++;
            if (n_printed < MaxPrint) begin
              n_printed++;
              $display("%0t: mismatch: expected byte %02h bv %b end %b len %0d last %b",
                       $time, want.data, want.is_byte, want.is_end, want.len, want.last);
              $display("%0t:           actual   byte %02h bv %b end %b len %0d last %b",
                       $time, out_byte_o, byte_valid_o, unit_end_o, unit_length_o,
                       last_of_input_o);
            end
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, MaxGap);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_ready_i <= rst_ni && (stall_left == 0);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  feed_t stream_buf[$];

  function automatic void add_byte(input logic [7:0] b, input logic ss = 1'b0,
                                   input logic se = 1'b0);
    feed_t f;
    f.data  = b;
    f.ss    = ss;
    f.se    = se;
    f.gap   = calm ? 0 : $urandom_range(0, MaxGap);
    f.drain = 1'b0;
    stream_buf.push_back(f);
  endfunction

  function automatic void flush_stream(input bit close);
    if (close && stream_buf.size() > 0) stream_buf[stream_buf.size()-1].se = 1'b1;
    foreach (stream_buf[i]) byte_feed.push_back(stream_buf[i]);
    stream_buf.delete();
  endfunction

  function automatic void add_drain();
    feed_t f;
    f       = '{8'h00, 1'b0, 1'b0, 0, 1'b1};
    byte_feed.push_back(f);
  endfunction

  // payload content leaning on the bytes that matter to the parser
  function automatic logic [7:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return ByteZero;
      3:       return ByteOne;
      4:       return 8'h03;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned n_rand;
    int unsigned nz;
    bit          first;

    // directed: leading junk dropped, zeros while searching, 4-byte start code
    add_byte(8'h55, 1'b1);
    add_byte(8'h01);
    add_byte(ByteZero); add_byte(ByteZero); add_byte(ByteZero);
    add_byte(ByteZero); add_byte(ByteZero); add_byte(ByteOne);
    // payload extremes, a 01 with no zeros, one and two held zeros released
    add_byte(8'hFF); add_byte(ByteOne);
    add_byte(ByteZero); add_byte(8'h80);
    add_byte(ByteZero); add_byte(ByteZero); add_byte(8'h7F);
    // long zero run inside a unit, then 3-byte start code closing it
    add_byte(ByteZero); add_byte(ByteZero); add_byte(ByteZero);
    add_byte(ByteZero); add_byte(ByteZero); add_byte(8'hAB);
    add_byte(ByteZero); add_byte(ByteZero); add_byte(ByteOne);
    // held zeros dropped at the stream end
    add_byte(8'h11); add_byte(ByteZero); add_byte(ByteZero, 1'b0, 1'b1);
    // start and end on one byte: empty unit
    add_byte(ByteZero, 1'b1, 1'b1);
    flush_stream(1'b0);
    add_drain();

    // random: mostly well-formed streams, some noise and broken start codes
    n_rand = 0;
    while (n_rand < RandBytes) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                              : 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 5) == 0), ($urandom_range(0, 5) == 0));
        end
        flush_stream(1'b0);
      end else begin
        first = 1'b1;
        repeat ($urandom_range(0, 3)) begin
          add_byte(8'($urandom_range(0, 255)), first);
          first = 1'b0;
        end
        repeat ($urandom_range(1, 4)) begin
          // start code of 3 or 4 bytes, now and then broken
          nz = $urandom_range(2, 3);
          if ($urandom_range(0, 7) == 0) nz = 1;
          repeat (nz) begin
            add_byte(ByteZero, first);
            first = 1'b0;
          end
          add_byte(($urandom_range(0, 9) == 0) ? 8'h02 : ByteOne);
          repeat ($urandom_range(1, 8)) add_byte(pick_payload());
        end
        flush_stream(1'b1);
      end
      n_rand = byte_feed.size();
      if (n_rand > 130 && n_drains == 0 && byte_feed.size() < 160) add_drain();
    end
    calm = 1'b0;
    // the stream has to end to flush the last unit; a few results-heavy runs last
    add_byte(ByteZero, 1'b1); add_byte(ByteZero); add_byte(ByteOne);
    repeat (6) add_byte(ByteZero);
    add_byte(8'hC3, 1'b0, 1'b1);
    flush_stream(1'b0);
    feed_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------
  initial begin
    wait (feed_done);
    while (byte_feed.size() > 0 || staged_ok || in_valid_i) @(posedge clk_i);
    while (expected_out.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d stream bytes, %0d results checked, %0d of them end markers",
             n_bytes_in, n_checked, n_markers);
    $display("sender drained the block %0d times, %0d failures", n_drains, n_errors);
    if (n_errors == 0 && expected_out.size() == 0) begin
      $display("nal_start_code_splitter regression: pass");
    end else begin
      $display("nal_start_code_splitter regression: fail");
    end
    $finish;
  end

  // generous watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", expected_out.size());
    $display("nal_start_code_splitter regression: fail");
    $finish;
  end

endmodule
